/* sv/sorted_table_binary_search_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table search core
// Immediate-implication and next-cycle-implication property checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define STBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define STBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and sizing constants for the sorted table search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

   // table sizing
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   // one probe stage per halving step of the widest range
   localparam int PROBES      = $clog2(TABLE_DEPTH + 1);
   // signed width that holds lo/hi over -1 .. TABLE_DEPTH
   localparam int LH_W        = ADDR_W + 2;

   // fixed field widths
   localparam int KEY_W   = 32;
   localparam int POSIN_W = 10;
   localparam int POSOUT_W = 11;
   localparam int COUNT_W = 11;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_EXACT = 2'd1,
      FUNC_FLOOR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // one item as it travels down the pipeline
   typedef struct packed {
      logic                    vld;
      func_type                func;
      logic [ADDR_W-1:0]       wpos;
      logic                    wr_ok;
      logic [KEY_W-1:0]        key;
      logic signed [LH_W-1:0]  lo;
      logic signed [LH_W-1:0]  hi;
      logic signed [LH_W-1:0]  last;
      logic signed [LH_W-1:0]  res;
      logic                    done;
   } item_type;

endpackage

/* sv/stbs_if.sv */
// ----------------------------------------------------------------------------
// stbs channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// request channel: write or search item
interface stbs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [9:0]  position_in;
   logic [31:0] key;

   modport source (output valid, func, position_in, key, input ready);
   modport sink   (input valid, func, position_in, key, output ready);
endinterface

// response channel: search result
interface stbs_rsp_if;
   logic              valid;
   logic              ready;
   logic              found;
   logic signed [10:0] position_out;

   modport source (output valid, found, position_out, input ready);
   modport sink   (input valid, found, position_out, output ready);
endinterface

// register write channel: entry count
interface stbs_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] entry_count;

   modport source (output valid, entry_count, input ready);
   modport sink   (input valid, entry_count, output ready);
endinterface

/* sv/sorted_table_binary_search_core.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Pipelined halving search over an ascending table of 32-bit keys, with
// in-order table writes and exact or floor search results.
//
//   channel  direction  carries
//   req_ch   in         func, position_in, key
//   rsp_ch   out        found, position_out
//   csr_ch   in         entry_count
//
// One item enters per cycle while the response is not stalled; a search result
// passes the entry register, the chain of probe stages, each with its own
// table copy and one RAM read per stage, and the output register.
// A stalled response freezes the whole pipeline; nothing is dropped.
// Reset clears the valid bits and entry_count; the table is not cleared.
// csr_ch is always ready; write it only while the core is idle.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_core_defines.svh"

module sorted_table_binary_search_core (
   input  logic            clock,
   input  logic            reset,
   stbs_req_if.sink        req_ch,
   stbs_rsp_if.source      rsp_ch,
   stbs_csr_if.sink        csr_ch
);

   logic [stbs_pkg::COUNT_W-1:0]   count_ff;
   logic [stbs_pkg::LH_W-1:0]      cnt_sat;
   logic                           adv;
   stbs_pkg::item_type             e_ff;
   stbs_pkg::item_type             e_in;
   stbs_pkg::item_type             chain [stbs_pkg::PROBES+1];
   stbs_pkg::item_type             tail;
   stbs_pkg::func_type             req_func;
   logic signed [stbs_pkg::LH_W-1:0] res_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           found_ff;
   logic [stbs_pkg::POSOUT_W-1:0]  pos_ff;
   logic                           tail_search;

   // entry count register
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_ch.valid) begin
         count_ff <= csr_ch.entry_count;
      end
   end

   assign cnt_sat = (32'(count_ff) > 32'(stbs_pkg::TABLE_DEPTH)) ?
                    stbs_pkg::LH_W'(stbs_pkg::TABLE_DEPTH) : stbs_pkg::LH_W'(count_ff);

   // pipeline advances whenever the output slot is free or being taken
   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // entry stage: start a full range
   assign req_func = stbs_pkg::func_type'(req_ch.func);

   always_comb begin
      e_in.vld   = req_ch.valid && (req_func != stbs_pkg::FUNC_NONE);
      e_in.func  = req_func;
      e_in.wpos  = stbs_pkg::ADDR_W'(req_ch.position_in);
      e_in.wr_ok = 32'(req_ch.position_in) < 32'(stbs_pkg::TABLE_DEPTH);
      e_in.key   = req_ch.key;
      e_in.lo    = '0;
      e_in.hi    = $signed(cnt_sat) - stbs_pkg::LH_W'(1);
      e_in.last  = $signed(cnt_sat) - stbs_pkg::LH_W'(1);
      e_in.res   = '1;
      e_in.done  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff.vld <= 1'b0;
      end else if (adv) begin
         e_ff <= e_in;
      end
   end

   // probe stages
   assign chain[0] = e_ff;

   for (genvar k = 0; k < stbs_pkg::PROBES; k++) begin : g_stage
      stbs_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_item  (chain[k]),
         .out_item (chain[k+1])
      );
   end

   assign tail = chain[stbs_pkg::PROBES];

   // final result: miss handling for exact and floor modes
   assign tail_search = (tail.func == stbs_pkg::FUNC_EXACT) ||
                        (tail.func == stbs_pkg::FUNC_FLOOR);

   always_comb begin
      res_in = tail.res;
      if (!tail.done) begin
         if (tail.func == stbs_pkg::FUNC_FLOOR) begin
            res_in = ($signed(tail.hi) < 0) ? tail.last : tail.hi;
         end else begin
            res_in = '1;
         end
      end
   end

   assign rsp_valid_in = tail.vld && tail_search;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         found_ff <= !res_in[stbs_pkg::LH_W-1];
         pos_ff   <= res_in[stbs_pkg::POSOUT_W-1:0];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = found_ff;
   assign rsp_ch.position_out = pos_ff;

   // checks
   `STBS_ASSERT_NXT(a_unused_dropped, clock, reset,
      req_ch.valid && req_ch.ready && (req_func == stbs_pkg::FUNC_NONE), !e_ff.vld,
      "unused selector entered the pipeline")

   `STBS_ASSERT_NOW(a_found_sign, clock, reset,
      rsp_valid_ff, found_ff == !pos_ff[stbs_pkg::POSOUT_W-1],
      "found flag disagrees with position sign")

   `STBS_ASSERT_NOW(a_found_in_range, clock, reset,
      rsp_valid_ff && found_ff, 32'(pos_ff) < 32'(cnt_sat),
      "found position beyond entry count")

   `STBS_ASSERT_NOW(a_search_exhausted, clock, reset,
      tail.vld && tail_search && !tail.done, $signed(tail.lo) > $signed(tail.hi),
      "search range left open after last probe stage")

endmodule

/* sv/stbs_ram.sv */
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port RAM with registered read, read data held when idle.
// ----------------------------------------------------------------------------
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read, one access a cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/stbs_stage.sv */
// ----------------------------------------------------------------------------
// stbs_stage
// One halving step: issue a probe to this stage's table copy, then compare
// the probe with the key and narrow the range. Writes update the copy as
// they pass, so every search sees exactly the writes ahead of it.
// ----------------------------------------------------------------------------
module stbs_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  stbs_pkg::item_type in_item,
   output stbs_pkg::item_type out_item
);

   stbs_pkg::item_type t_ff;
   stbs_pkg::item_type s_ff;
   stbs_pkg::item_type s_in;
   logic signed [stbs_pkg::LH_W-1:0] mid_ff;
   logic signed [stbs_pkg::LH_W-1:0] mid_in;
   logic signed [stbs_pkg::LH_W:0]   sum;
   logic [stbs_pkg::ADDR_W-1:0]      ram_addr;
   logic [stbs_pkg::KEY_W-1:0]       probe;
   logic                             ram_we;
   logic                             active;

   // midpoint, rounded down (lo is never negative when it is used)
   assign sum    = (stbs_pkg::LH_W+1)'(in_item.lo) + (stbs_pkg::LH_W+1)'(in_item.hi);
   assign mid_in = sum[stbs_pkg::LH_W:1];

   // write items store their key, search items read at the midpoint
   assign ram_we   = adv && in_item.vld && (in_item.func == stbs_pkg::FUNC_WRITE)
                     && in_item.wr_ok;
   assign ram_addr = (in_item.func == stbs_pkg::FUNC_WRITE) ?
                     in_item.wpos : mid_in[stbs_pkg::ADDR_W-1:0];

   stbs_ram #(
      .WIDTH (stbs_pkg::KEY_W),
      .DEPTH (stbs_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (adv),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (in_item.key),
      .rdata (probe)
   );

   // address stage
   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff.vld <= 1'b0;
      end else if (adv) begin
         t_ff   <= in_item;
         mid_ff <= mid_in;
      end
   end

   // compare and narrow
   assign active = ((t_ff.func == stbs_pkg::FUNC_EXACT) ||
                    (t_ff.func == stbs_pkg::FUNC_FLOOR)) &&
                   !t_ff.done && ($signed(t_ff.lo) <= $signed(t_ff.hi));

   always_comb begin
      s_in = t_ff;
      if (active) begin
         if (probe == t_ff.key) begin
            s_in.done = 1'b1;
            s_in.res  = mid_ff;
         end else if (probe > t_ff.key) begin
            s_in.hi = mid_ff - stbs_pkg::LH_W'(1);
         end else begin
            s_in.lo = mid_ff + stbs_pkg::LH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff.vld <= 1'b0;
      end else if (adv) begin
         s_ff <= s_in;
      end
   end

   assign out_item = s_ff;

endmodule

/* tb/sorted_table_binary_search_core_tb.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core_tb
// Self-checking bench for the table search core. Table writes and exact or
// floor searches are driven over the request channel under random bursts
// and gaps. A shadow copy of the table and of entry_count predicts every
// search result, and each result transfer is checked in order against it.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core_tb;
   import stbs_pkg::*;

   // pipeline depth of the core, used for settle and tail waits
   localparam int LATENCY     = 2 * PROBES + 2;
   localparam int LONG_HOLD   = 300;
   localparam int RANDOM_ITEMS = 600;

   typedef struct packed {
      logic                found;
      logic [POSOUT_W-1:0] position;
   } search_outcome_type;

   // shadow table, count register and the queue of outstanding search results
   class search_checker;
      logic [KEY_W-1:0]   key_store [TABLE_DEPTH];
      int unsigned        entry_count;
      search_outcome_type outcome_q [$];
      int                 errors;

      function void set_count(int unsigned value);
         entry_count = value;
      endfunction

      // halving search over the shadow table
      function search_outcome_type lookup(logic [KEY_W-1:0] target, bit floor_mode);
         int                 span;
         int                 lo;
         int                 hi;
         int                 mid;
         search_outcome_type res;
         span = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
         lo   = 0;
         hi   = span - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key_store[mid] == target) begin
               res.found    = 1'b1;
               res.position = POSOUT_W'(mid);
               return res;
            end
            if (key_store[mid] > target) hi = mid - 1;
            else lo = mid + 1;
         end
         // floor below every entry wraps to the last valid entry
         if (floor_mode && hi < 0) hi = span - 1;
         if (!floor_mode || hi < 0) begin
            res.found    = 1'b0;
            res.position = '1;
         end else begin
            res.found    = 1'b1;
            res.position = POSOUT_W'(hi);
         end
         return res;
      endfunction

      // called on every accepted request transfer
      function void accept_item(func_type f, logic [POSIN_W-1:0] pos, logic [KEY_W-1:0] k);
         case (f)
            FUNC_WRITE: key_store[pos] = k;
            FUNC_EXACT: outcome_q.push_back(lookup(k, 1'b0));
            FUNC_FLOOR: outcome_q.push_back(lookup(k, 1'b1));
            default: ;
         endcase
      endfunction

      // called on every accepted response transfer
      function void check_outcome(logic found, logic [POSOUT_W-1:0] position);
         search_outcome_type exp_res;
         if (outcome_q.size() == 0) begin
            $error("result with none expected: found %0d position_out %0d",
                   found, $signed(position));
            errors++;
            return;
         end
         exp_res = outcome_q.pop_front();
         if (found !== exp_res.found) begin
            $error("found: expected %0d, actual %0d", exp_res.found, found);
            errors++;
         end
         if (position !== exp_res.position) begin
            $error("position_out: expected %0d, actual %0d",
                   $signed(exp_res.position), $signed(position));
            errors++;
         end
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   stbs_req_if req_ch ();
   stbs_rsp_if rsp_ch ();
   stbs_csr_if csr_ch ();

   sorted_table_binary_search_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   search_checker lookup_chk = new();

   int burst_left   = 0;
   bit steady       = 1'b0;
   bit hold_request = 1'b0;
   int sent         = 0;

   // clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // hard limit on the run
   initial begin
      #2000000;
      $display("sorted_table_binary_search_core_tb failed");
      $finish;
   end

   // result side: stall pattern plus a long hold-off on request
   initial begin
      int mode;
      int left;
      int hold_left;
      int tick;
      mode      = 0;
      left      = 0;
      hold_left = 0;
      tick      = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(8, 60);
            end
            left--;
            tick++;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= (tick % 4 != 0);
               default: rsp_ch.ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // result transfer monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         lookup_chk.check_outcome(rsp_ch.found, rsp_ch.position_out);
   end

   // one request transfer, with a random gap between bursts
   task automatic send_item(input func_type f, input logic [POSIN_W-1:0] pos,
                            input logic [KEY_W-1:0] k);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.func        <= f;
      req_ch.position_in <= pos;
      req_ch.key         <= k;
      do @(posedge clock); while (!req_ch.ready);
      lookup_chk.accept_item(f, pos, k);
      if (f != FUNC_NONE) sent++;
   endtask

   // stop sending until every outstanding result has been received
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (lookup_chk.pending() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // entry_count write, only with the core empty
   task automatic write_count(input logic [COUNT_W-1:0] value);
      wait_idle();
      // table writes give no result and may still be in flight
      repeat (LATENCY + 8) @(posedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.entry_count <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      lookup_chk.set_count(value);
   endtask

   // one random item: mostly hits and near misses, some order-keeping writes
   task automatic random_item();
      int unsigned       eff;
      int unsigned       idx;
      int unsigned       pick;
      func_type          f;
      logic [KEY_W-1:0]  k;
      logic [KEY_W-1:0]  lo_k;
      logic [KEY_W-1:0]  hi_k;
      logic [POSIN_W-1:0] p;
      longint unsigned   span;
      longint unsigned   r;
      eff  = (lookup_chk.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : lookup_chk.entry_count;
      f    = ($urandom_range(0, 1) != 0) ? FUNC_EXACT : FUNC_FLOOR;
      pick = $urandom_range(0, 99);
      idx  = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
      p    = POSIN_W'($urandom);
      if (pick < 50 && eff > 0) begin
         send_item(f, p, lookup_chk.key_store[idx]);
      end else if (pick < 65 && eff > 0) begin
         k = lookup_chk.key_store[idx];
         k = ($urandom_range(0, 1) != 0) ? k + 32'd1 : k - 32'd1;
         send_item(f, p, k);
      end else if (pick < 75) begin
         case ($urandom_range(0, 2))
            0: k = '0;
            1: k = '1;
            default: k = $urandom;
         endcase
         send_item(f, p, k);
      end else if (pick < 95) begin
         // new key between the neighbors keeps the table ascending
         lo_k = (p > 0) ? lookup_chk.key_store[p - 1] : '0;
         hi_k = (p < TABLE_DEPTH - 1) ? lookup_chk.key_store[p + 1] : '1;
         if (hi_k < lo_k) begin
            k = lo_k;
         end else begin
            span = longint'(hi_k) - longint'(lo_k) + 1;
            r    = {$urandom, $urandom};
            k    = lo_k + KEY_W'(r % span);
         end
         send_item(FUNC_WRITE, p, k);
      end else if (pick < 97) begin
         send_item(FUNC_WRITE, p, $urandom);
      end else begin
         send_item(FUNC_NONE, p, $urandom);
      end
   endtask

   // stimulus
   initial begin
      int              phase;
      int              n;
      int              start_count;
      longint unsigned acc;
      logic [COUNT_W-1:0] cnt;

      reset = 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= FUNC_WRITE;
      req_ch.position_in <= '0;
      req_ch.key         <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.entry_count <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: both searches miss, no probe is compared
      send_item(FUNC_EXACT, '0, '0);
      send_item(FUNC_FLOOR, '1, '1);
      send_item(FUNC_NONE, '1, '1);

      // small table with a duplicate and the top key
      send_item(FUNC_WRITE, 10'd0, 32'd10);
      send_item(FUNC_WRITE, 10'd1, 32'd20);
      send_item(FUNC_WRITE, 10'd2, 32'd20);
      send_item(FUNC_WRITE, 10'd3, '1);
      send_item(FUNC_WRITE, 10'd4, 32'd30);
      send_item(FUNC_WRITE, '1, '0);
      write_count(11'd4);
      send_item(FUNC_EXACT, '0, 32'd10);
      send_item(FUNC_EXACT, '0, 32'd20);
      send_item(FUNC_EXACT, '0, '1);
      send_item(FUNC_EXACT, '0, 32'd15);
      send_item(FUNC_EXACT, '0, '0);
      send_item(FUNC_FLOOR, '0, 32'd15);
      // floor below every entry
      send_item(FUNC_FLOOR, '0, '0);
      send_item(FUNC_FLOOR, '0, 32'hFFFF_FFFE);
      send_item(FUNC_FLOOR, '0, 32'd25);

      // fill the whole table with ascending keys, duplicates allowed
      acc = $urandom_range(0, 50);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_item(FUNC_WRITE, POSIN_W'(i), KEY_W'(acc));
         acc = acc + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4000000));
         if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      end

      // random phases, each under its own entry_count
      start_count = sent;
      phase = 0;
      while (sent - start_count < RANDOM_ITEMS) begin
         case (phase)
            0: cnt = 11'd1;
            1: cnt = 11'd2;
            2: cnt = 11'd1024;
            3: cnt = 11'd2047;
            4: cnt = 11'd0;
            5: cnt = 11'd3;
            6: cnt = 11'd1025;
            default: cnt = ($urandom_range(0, 2) == 0) ? COUNT_W'($urandom_range(0, 2047))
                                                       : COUNT_W'($urandom_range(1, 64));
         endcase
         write_count(cnt);
         steady = (phase % 4 == 1);
         n = $urandom_range(80, 200);
         // receiver holds off while requests keep coming
         if (phase == 2 || phase == 8) begin
            hold_request = 1'b1;
            steady       = 1'b1;
         end
         repeat (n) random_item();
         phase++;
      end

      wait_idle();
      repeat (2 * LATENCY) @(posedge clock);
      if (lookup_chk.errors == 0 && lookup_chk.pending() == 0)
         $display("sorted_table_binary_search_core_tb passed");
      else
         $display("sorted_table_binary_search_core_tb failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/stbs_pkg.sv
sv/stbs_if.sv
sv/stbs_ram.sv
sv/stbs_stage.sv
sv/sorted_table_binary_search_core.sv
tb/sorted_table_binary_search_core_tb.sv
